@@ rtl/ppbc_pkg.sv @@
// Shared types and constants for the PTZ preset blend command block.
package ppbc_pkg;

  localparam int TableDepthDef = 64;

  // configuration register indexes
  localparam logic [1:0] CFG_HEADER = 2'd0;
  localparam logic [1:0] CFG_PAN_SPEED = 2'd1;
  localparam logic [1:0] CFG_TILT_SPEED = 2'd2;

  localparam logic [7:0] HEADER_RST = 8'h81;
  localparam logic [7:0] PAN_SPEED_RST = 8'h12;
  localparam logic [7:0] TILT_SPEED_RST = 8'h0e;

  localparam logic [7:0] BYTE_01 = 8'h01;
  localparam logic [7:0] BYTE_06 = 8'h06;
  localparam logic [7:0] BYTE_02 = 8'h02;
  localparam logic [7:0] BYTE_04 = 8'h04;
  localparam logic [7:0] BYTE_47 = 8'h47;
  localparam logic [7:0] BYTE_FF = 8'hff;

  localparam int PacketLen = 24;

  // one queued transaction between front and back
  typedef struct packed {
    logic        cmd;
    logic [15:0] id_a;
    logic [7:0]  weight_a;
    logic [15:0] id_b;
    logic [7:0]  weight_b;
    logic [15:0] id_c;
    logic [7:0]  weight_c;
    logic [15:0] id_d;
    logic [7:0]  weight_d;
    logic [15:0] pan_in;
    logic [15:0] tilt_in;
    logic [15:0] zoom_in;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_SEND,
    ST_ADD
  } back_state_t;

endpackage

@@ rtl/ppbc_queue.sv @@
// Two-entry queue that decouples the input front from the command back end.
module ppbc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ppbc_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output ppbc_pkg::item_t out_item
);

  ppbc_pkg::item_t slot [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_item  = slot[rd_ptr];

  // pointer and fill bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        slot[wr_ptr] <= in_item;
        wr_ptr       <= ~wr_ptr;
      end
      if (out_valid && out_ready) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end

endmodule

@@ rtl/ppbc_divider.sv @@
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
module ppbc_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [26:0] num,
  input  logic signed [10:0] den,
  output logic               done,
  output logic [15:0]        quot
);

  logic [26:0] rem_q;
  logic [26:0] mag_n;
  logic [9:0]  mag_d;
  logic        neg;
  logic [4:0]  cnt;
  logic        busy;
  logic [27:0] trial;
  logic [26:0] q_res;

  assign trial = {rem_q, mag_n[26]} - {18'd0, mag_d};
  assign q_res = neg ? (~mag_n + 27'd1) : mag_n;

  // restoring division; mag_n shifts out dividend bits and in quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 5'd0;
        rem_q <= 27'd0;
        mag_n <= num[26] ? 27'(-num) : 27'(num);
        mag_d <= den[9:0];
        neg   <= num[26];
      end else if (busy) begin
        if (!trial[27]) begin
          rem_q <= trial[26:0];
          mag_n <= {mag_n[25:0], 1'b1};
        end else begin
          rem_q <= {rem_q[25:0], mag_n[26]};
          mag_n <= {mag_n[25:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd26) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q_res[15:0];

endmodule

@@ rtl/ppbc_back.sv @@
// Back end: preset table, lookup scan, blend division and packet serialiser.
module ppbc_back #(
  parameter int TABLE_DEPTH = ppbc_pkg::TableDepthDef
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  ppbc_pkg::item_t item,
  input  logic [7:0]      camera_header,
  input  logic [7:0]      pan_speed,
  input  logic [7:0]      tilt_speed,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      packet_byte,
  output logic            last_byte,
  output logic            accepted
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  ppbc_pkg::back_state_t state, state_next;

  logic [63:0]       store [TABLE_DEPTH];
  logic [CW-1:0]     count;
  ppbc_pkg::item_t   cur;
  logic [CW-1:0]     scan;
  logic [63:0]       rd_data;
  logic              rd_live;
  logic [3:0]        found;
  logic [IW-1:0]     fidx [4];
  logic [1:0]        slot;
  logic [2:0]        axis;
  logic signed [26:0] acc_p, acc_t, acc_z;
  logic signed [10:0] acc_w;
  logic [15:0]       res_p, res_t, res_z;
  logic [1:0]        phase;
  logic              div_start, div_done;
  logic [15:0]       div_q;
  logic [4:0]        bidx;
  logic              add_ok;

  logic [15:0] ids [4];
  logic [7:0]  wts [4];
  assign ids[0] = cur.id_a; assign ids[1] = cur.id_b;
  assign ids[2] = cur.id_c; assign ids[3] = cur.id_d;
  assign wts[0] = cur.weight_a; assign wts[1] = cur.weight_b;
  assign wts[2] = cur.weight_c; assign wts[3] = cur.weight_d;

  assign item_ready = (state == ppbc_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ppbc_pkg::ST_IDLE: if (item_valid)
        state_next = item.cmd ? ppbc_pkg::ST_SCAN : ppbc_pkg::ST_ADD;
      ppbc_pkg::ST_SCAN: if (scan == count && !rd_live && axis == 3'd4)
        state_next = ppbc_pkg::ST_DIV;
      ppbc_pkg::ST_DIV: if (div_done && phase == 2'd2) state_next = ppbc_pkg::ST_SEND;
      ppbc_pkg::ST_SEND: if (out_ready && bidx == 5'(ppbc_pkg::PacketLen - 1))
        state_next = ppbc_pkg::ST_IDLE;
      ppbc_pkg::ST_ADD: if (out_ready) state_next = ppbc_pkg::ST_IDLE;
      default: state_next = ppbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ppbc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // table writes, scan of ids, accumulation of the weighted sums
  always_ff @(posedge clk) begin
    logic signed [7:0]  w;
    if (rst) begin
      count   <= '0;
      rd_live <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      rd_live   <= 1'b0;
      unique case (state)
        ppbc_pkg::ST_IDLE: if (item_valid) begin
          cur   <= item;
          scan  <= '0;
          found <= 4'd0;
          axis  <= 3'd0;
          bidx  <= 5'd0;
          acc_p <= '0; acc_t <= '0; acc_z <= '0; acc_w <= '0;
          if (!item.cmd) begin
            add_ok <= (count < CW'(TABLE_DEPTH));
            if (count < CW'(TABLE_DEPTH)) begin
              store[count[IW-1:0]] <= {item.id_a, item.pan_in, item.tilt_in, item.zoom_in};
              count <= count + 1'b1;
            end
          end
        end
        ppbc_pkg::ST_SCAN: begin
          if (scan != count) begin
            rd_data <= store[scan[IW-1:0]];
            rd_live <= 1'b1;
            scan    <= scan + 1'b1;
          end
          if (rd_live) begin
            for (int k = 0; k < 4; k++)
              if (!found[k] && rd_data[63:48] == ids[k]) begin
                found[k] <= 1'b1;
                fidx[k]  <= IW'(scan - 1'b1);
              end
          end
          // once scan finished, fetch each slot's entry and accumulate one per cycle
          if (scan == count && !rd_live && axis != 3'd4) begin
            if (axis == 3'd0) begin
              rd_data <= store[fidx[2'd0]];
              slot <= 2'd0;
              axis <= 3'd1;
            end else begin
              w = signed'(wts[slot]);
              if (found[slot]) begin
                acc_p <= acc_p + 27'(signed'(rd_data[47:32])) * w;
                acc_t <= acc_t + 27'(signed'(rd_data[31:16])) * w;
                acc_z <= acc_z + 27'(signed'(rd_data[15:0])) * w;
                acc_w <= acc_w + 11'(w);
              end
              rd_data <= store[fidx[slot + 2'd1]];
              slot <= slot + 2'd1;
              if (slot == 2'd3) begin
                axis <= 3'd4;
                div_start <= 1'b1;
              end
            end
          end
          phase <= 2'd0;
        end
        ppbc_pkg::ST_DIV: if (div_done) begin
          unique case (phase)
            2'd0: res_p <= (acc_w > 0) ? div_q : 16'd0;
            2'd1: res_t <= (acc_w > 0) ? div_q : 16'd0;
            default: res_z <= (acc_w > 0) ? div_q : 16'd0;
          endcase
          phase <= phase + 2'd1;
          if (phase != 2'd2) div_start <= 1'b1;
        end
        ppbc_pkg::ST_SEND: if (out_ready) bidx <= bidx + 5'd1;
        default: ;
      endcase
    end
  end

  logic signed [26:0] div_num;
  always_comb begin
    unique case (phase)
      2'd0:    div_num = acc_p;
      2'd1:    div_num = acc_t;
      default: div_num = acc_z;
    endcase
  end

  ppbc_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(div_num), .den((acc_w > 0) ? acc_w : 11'sd1),
    .done(div_done), .quot(div_q)
  );

  // packet byte selection
  always_comb begin
    unique case (bidx)
      5'd0, 5'd15: packet_byte = camera_header;
      5'd1, 5'd16: packet_byte = ppbc_pkg::BYTE_01;
      5'd2:  packet_byte = ppbc_pkg::BYTE_06;
      5'd3:  packet_byte = ppbc_pkg::BYTE_02;
      5'd4:  packet_byte = pan_speed;
      5'd5:  packet_byte = tilt_speed;
      5'd6:  packet_byte = {4'd0, res_p[15:12]};
      5'd7:  packet_byte = {4'd0, res_p[11:8]};
      5'd8:  packet_byte = {4'd0, res_p[7:4]};
      5'd9:  packet_byte = {4'd0, res_p[3:0]};
      5'd10: packet_byte = {4'd0, res_t[15:12]};
      5'd11: packet_byte = {4'd0, res_t[11:8]};
      5'd12: packet_byte = {4'd0, res_t[7:4]};
      5'd13: packet_byte = {4'd0, res_t[3:0]};
      5'd14, 5'd23: packet_byte = ppbc_pkg::BYTE_FF;
      5'd17: packet_byte = ppbc_pkg::BYTE_04;
      5'd18: packet_byte = ppbc_pkg::BYTE_47;
      5'd19: packet_byte = {4'd0, res_z[15:12]};
      5'd20: packet_byte = {4'd0, res_z[11:8]};
      5'd21: packet_byte = {4'd0, res_z[7:4]};
      5'd22: packet_byte = {4'd0, res_z[3:0]};
      default: packet_byte = 8'd0;
    endcase
    if (state == ppbc_pkg::ST_ADD) packet_byte = 8'd0;
  end

  assign out_valid = (state == ppbc_pkg::ST_SEND) || (state == ppbc_pkg::ST_ADD);
  assign last_byte = (state == ppbc_pkg::ST_ADD) ||
                     (bidx == 5'(ppbc_pkg::PacketLen - 1));
  assign accepted  = (state == ppbc_pkg::ST_ADD) ? add_ok : 1'b1;

endmodule

@@ rtl/ptz_preset_blend_command_top.sv @@
// Top level: PTZ preset table with blended goto command packets.
// An add answers with a single byte carrying accepted; a goto scans the written entries,
// fetches and accumulates each found entry, runs three 27-step divisions (pan, tilt, zoom),
// then sends 24 bytes. The back end takes one transaction at a time and a goto is bound
// by the bit-serial divider; a two-entry queue buffers inputs.
// Reset clears the entry count, queue pointers, state and configuration registers; table contents are not cleared.
module ptz_preset_blend_command_top #(
  parameter int TABLE_DEPTH = ppbc_pkg::TableDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [15:0] id_a,
  input  logic signed [7:0] weight_a,
  input  logic [15:0] id_b,
  input  logic signed [7:0] weight_b,
  input  logic [15:0] id_c,
  input  logic signed [7:0] weight_c,
  input  logic [15:0] id_d,
  input  logic signed [7:0] weight_d,
  input  logic signed [15:0] pan_in,
  input  logic signed [15:0] tilt_in,
  input  logic signed [15:0] zoom_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  packet_byte,
  output logic        last_byte,
  output logic        accepted,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] camera_header, pan_speed, tilt_speed;
  ppbc_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_header <= ppbc_pkg::HEADER_RST;
      pan_speed     <= ppbc_pkg::PAN_SPEED_RST;
      tilt_speed    <= ppbc_pkg::TILT_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppbc_pkg::CFG_HEADER:     camera_header <= cfg_data;
        ppbc_pkg::CFG_PAN_SPEED:  pan_speed     <= cfg_data;
        ppbc_pkg::CFG_TILT_SPEED: tilt_speed    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item = '{cmd: cmd, id_a: id_a, weight_a: weight_a, id_b: id_b,
                     weight_b: weight_b, id_c: id_c, weight_c: weight_c,
                     id_d: id_d, weight_d: weight_d, pan_in: pan_in,
                     tilt_in: tilt_in, zoom_in: zoom_in};

  ppbc_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  ppbc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .camera_header(camera_header), .pan_speed(pan_speed), .tilt_speed(tilt_speed),
    .out_valid(out_valid), .out_ready(out_ready), .packet_byte(packet_byte),
    .last_byte(last_byte), .accepted(accepted)
  );

endmodule

@@ tb/tb.sv @@
// Testbench for the PTZ preset blend command block: predicts packets and checks each byte.
module tb;

  localparam int Depth = ppbc_pkg::TableDepthDef;
  localparam logic [1:0] CfgUnused = 2'd3;  // index with no register behind it

  typedef struct {
    logic [7:0] pbyte;
    logic       lastb;
    logic       acc;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [15:0] id_a = '0, id_b = '0, id_c = '0, id_d = '0;
  logic signed [7:0] weight_a = '0, weight_b = '0, weight_c = '0, weight_d = '0;
  logic signed [15:0] pan_in = '0, tilt_in = '0, zoom_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] packet_byte;
  logic last_byte, accepted;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // predictor state
  logic [15:0] pt_id [Depth];
  logic [15:0] pt_pan [Depth];
  logic [15:0] pt_tilt [Depth];
  logic [15:0] pt_zoom [Depth];
  int pt_count = 0;
  logic [7:0] hdr = ppbc_pkg::HEADER_RST, pspd = ppbc_pkg::PAN_SPEED_RST;
  logic [7:0] tspd = ppbc_pkg::TILT_SPEED_RST;

  out_beat_t expected_beats[$];
  int mismatches = 0;
  int send_idle = 0, recv_idle = 0;  // percent
  logic [15:0] known_ids[$];

  ptz_preset_blend_command_top u_dut (.*);

  initial forever #2 clk = ~clk;

  // random output stall
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [15:0] avg16(longint num, longint den);
    if (den <= 0) return 16'd0;
    return 16'(num / den);
  endfunction

  function automatic int find_pt(logic [15:0] id);
    for (int i = 0; i < pt_count; i++) if (pt_id[i] == id) return i;
    return -1;
  endfunction

  task automatic push_beat(logic [7:0] b, logic l, logic a);
    out_beat_t t;
    t.pbyte = b; t.lastb = l; t.acc = a;
    expected_beats.push_back(t);
  endtask

  task automatic push_nib(logic [15:0] v);
    for (int s = 3; s >= 0; s--) push_beat({4'h0, v[s*4 +: 4]}, 1'b0, 1'b1);
  endtask

  // work out the expected bytes of one transaction
  task automatic predict_blend(logic c, logic [15:0] ids[4], logic [7:0] ws[4],
                               logic [15:0] p, logic [15:0] t, logic [15:0] z);
    longint sp, st, sz, sw;
    int idx;
    logic [15:0] ap, at, az;
    if (!c) begin
      if (pt_count < Depth) begin
        pt_id[pt_count] = ids[0]; pt_pan[pt_count] = p;
        pt_tilt[pt_count] = t; pt_zoom[pt_count] = z;
        pt_count++;
        push_beat(8'h00, 1'b1, 1'b1);
      end else push_beat(8'h00, 1'b1, 1'b0);
      return;
    end
    sp = 0; st = 0; sz = 0; sw = 0;
    for (int k = 0; k < 4; k++) begin
      idx = find_pt(ids[k]);
      if (idx >= 0) begin
        sp += longint'($signed(pt_pan[idx])) * longint'($signed(ws[k]));
        st += longint'($signed(pt_tilt[idx])) * longint'($signed(ws[k]));
        sz += longint'($signed(pt_zoom[idx])) * longint'($signed(ws[k]));
        sw += longint'($signed(ws[k]));
      end
    end
    ap = avg16(sp, sw); at = avg16(st, sw); az = avg16(sz, sw);
    push_beat(hdr, 0, 1); push_beat(ppbc_pkg::BYTE_01, 0, 1);
    push_beat(ppbc_pkg::BYTE_06, 0, 1);
    push_beat(ppbc_pkg::BYTE_02, 0, 1); push_beat(pspd, 0, 1); push_beat(tspd, 0, 1);
    push_nib(ap); push_nib(at);
    push_beat(ppbc_pkg::BYTE_FF, 0, 1); push_beat(hdr, 0, 1);
    push_beat(ppbc_pkg::BYTE_01, 0, 1);
    push_beat(ppbc_pkg::BYTE_04, 0, 1); push_beat(ppbc_pkg::BYTE_47, 0, 1);
    push_nib(az);
    push_beat(ppbc_pkg::BYTE_FF, 1, 1);
  endtask

  // send one transaction, predicting at acceptance; valid drops when idling or draining
  task automatic send_item(logic c, logic [15:0] ids[4], logic [7:0] ws[4],
                           logic [15:0] p, logic [15:0] t, logic [15:0] z);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; cmd <= c;
    id_a <= ids[0]; id_b <= ids[1]; id_c <= ids[2]; id_d <= ids[3];
    weight_a <= ws[0]; weight_b <= ws[1]; weight_c <= ws[2]; weight_d <= ws[3];
    pan_in <= p; tilt_in <= t; zoom_in <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_blend(c, ids, ws, p, t, z);
    if (!c && pt_count <= Depth) known_ids.push_back(ids[0]);
  endtask

  // check each output transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected byte %h", packet_byte);
      end else begin
        out_beat_t e;
        e = expected_beats.pop_front();
        if (e.pbyte !== packet_byte || e.lastb !== last_byte || e.acc !== accepted) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h/%b/%b got %h/%b/%b", e.pbyte, e.lastb, e.acc,
                     packet_byte, last_byte, accepted);
        end
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] ix, logic [7:0] v);
    cfg_we <= 1'b1; cfg_index <= ix; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (ix)
      ppbc_pkg::CFG_HEADER: hdr = v;
      ppbc_pkg::CFG_PAN_SPEED: pspd = v;
      ppbc_pkg::CFG_TILT_SPEED: tspd = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_id();
    if (known_ids.size() != 0 && $urandom_range(9) < 8)
      return known_ids[$urandom_range(known_ids.size() - 1)];
    return 16'($urandom);
  endfunction

  task automatic random_goto();
    logic [15:0] ids[4];
    logic [7:0] ws[4];
    for (int k = 0; k < 4; k++) begin
      ids[k] = pick_id();
      ws[k] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(20));
    end
    send_item(1'b1, ids, ws, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic random_add();
    logic [15:0] ids[4];
    logic [7:0] ws[4];
    for (int k = 0; k < 4; k++) begin ids[k] = 16'($urandom); ws[k] = 8'($urandom); end
    if ($urandom_range(3) == 0 && known_ids.size() != 0) ids[0] = pick_id();
    send_item(1'b0, ids, ws, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // extremes, not-found ids, repeats, non-positive weight sums
  task automatic test_directed();
    logic [15:0] ids[4];
    logic [7:0] ws[4];
    ids = '{16'hffff, 0, 0, 0}; ws = '{0, 0, 0, 0};
    send_item(0, ids, ws, 16'h7fff, 16'h8000, 16'h7fff);
    ids = '{16'h0000, 0, 0, 0};
    send_item(0, ids, ws, 16'h8000, 16'h7fff, 16'h8000);
    ids = '{16'h1234, 0, 0, 0};
    send_item(0, ids, ws, 16'h0001, 16'hffff, 16'h0000);
    ids = '{16'hffff, 16'h0000, 16'h1234, 16'h5555}; ws = '{8'h7f, 8'h80, 8'h01, 8'h7f};
    send_item(1, ids, ws, 0, 0, 0);
    ws = '{8'h7f, 8'h7f, 8'h7f, 8'h7f};
    send_item(1, ids, ws, 0, 0, 0);
    ids = '{16'hffff, 16'hffff, 16'hffff, 16'hffff}; ws = '{8'h80, 8'h80, 8'h80, 8'h80};
    send_item(1, ids, ws, 0, 0, 0);
    ws = '{8'h05, 8'hfb, 8'h00, 8'h00};
    send_item(1, ids, ws, 0, 0, 0);
    ids = '{16'hffff, 16'h0000, 16'h0000, 16'h0000}; ws = '{8'h01, 8'h80, 8'h7f, 8'h03};
    send_item(1, ids, ws, 0, 0, 0);
    ids = '{16'h9999, 16'haaaa, 16'h0000, 16'h1234}; ws = '{8'h40, 8'h40, 8'hff, 8'h02};
    send_item(1, ids, ws, 0, 0, 0);
    ids = '{16'hffff, 16'h0000, 0, 0}; ws = '{8'h80, 8'h7f, 0, 0};
    send_item(1, ids, ws, 0, 0, 0);
    drain();
  endtask

  task automatic test_config();
    write_reg(ppbc_pkg::CFG_HEADER, 8'h00); write_reg(ppbc_pkg::CFG_PAN_SPEED, 8'hff);
    write_reg(ppbc_pkg::CFG_TILT_SPEED, 8'h00);
    repeat (4) random_goto();
    drain();
    write_reg(ppbc_pkg::CFG_HEADER, 8'hff); write_reg(ppbc_pkg::CFG_PAN_SPEED, 8'h00);
    write_reg(ppbc_pkg::CFG_TILT_SPEED, 8'hff);
    repeat (4) random_goto();
    drain();
    write_reg(CfgUnused, 8'h55);
    write_reg(ppbc_pkg::CFG_HEADER, ppbc_pkg::HEADER_RST);
    write_reg(ppbc_pkg::CFG_PAN_SPEED, ppbc_pkg::PAN_SPEED_RST);
    write_reg(ppbc_pkg::CFG_TILT_SPEED, ppbc_pkg::TILT_SPEED_RST);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0) random_add(); else random_goto();
    end
    drain();
  endtask

  // fill past capacity so later adds are refused
  task automatic test_table_full();
    while (pt_count < Depth) random_add();
    repeat (4) random_add();
    repeat (10) random_goto();
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 16; recv_idle = 52;
    test_directed();
    test_config();
    test_random(80);
    send_idle = 52; recv_idle = 16;
    test_random(80);
    send_idle = 0; recv_idle = 0;
    test_table_full();
    write_reg(ppbc_pkg::CFG_PAN_SPEED, 8'h3c);
    test_random(60);
    if (mismatches == 0 && expected_beats.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ppbc_pkg.sv
rtl/ppbc_queue.sv
rtl/ppbc_divider.sv
rtl/ppbc_back.sv
rtl/ptz_preset_blend_command_top.sv
tb/tb.sv
